// ===== rtl/voxel_grid_ray_traversal_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the voxel grid ray traversal block.
// Each macro expands into one labelled concurrent assertion on the main clock.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_TRAVERSAL_TOP_MACROS_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VGRT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vgrt: check failed");

// Consequent must hold in the cycle after the antecedent.
`define VGRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vgrt: check failed");

`endif

// ===== rtl/vgrt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vgrt_pkg
// Shared constants, types and helper functions of the voxel grid traversal.
// ============================================================================
package vgrt_pkg;

   localparam int CHUNK_WIDTH  = 16;
   localparam int WORLD_CHUNKS = 4;
   localparam int GRID_HEIGHT  = 64;
   localparam int ID_BITS      = 8;

   localparam int GRID_W     = CHUNK_WIDTH * WORLD_CHUNKS;
   localparam int STORE_SIZE = GRID_W * GRID_W * GRID_HEIGHT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_TRACE = 2'd2;

   localparam logic [31:0] T_SAT = 32'hFFFF_FFFF;

   // Divider request and response.
   typedef struct packed {
      logic        start;
      logic [30:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quo;
   } div_rsp_type;

   function automatic logic in_grid(logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z);
      int xi, yi, zi;
      xi = int'(x);
      yi = int'(y);
      zi = int'(z);
      return (xi >= 0) && (xi < GRID_W) && (zi >= 0) && (zi < GRID_W) &&
             (yi >= 0) && (yi < GRID_HEIGHT);
   endfunction

   // Linear address of an in-grid voxel: x major, then y, then z.
   function automatic logic [ADDR_W-1:0] cell_addr(logic signed [15:0] x,
                                                   logic signed [15:0] y,
                                                   logic signed [15:0] z);
      int a;
      a = (int'(x) * GRID_HEIGHT + int'(y)) * GRID_W + int'(z);
      return a[ADDR_W-1:0];
   endfunction

   // Neighbour chunk borders of an in-grid voxel: bit0 -x, bit1 +x, bit2 -z, bit3 +z.
   function automatic logic [3:0] redraw_bits(logic signed [15:0] x, logic signed [15:0] z);
      int xi, zi;
      logic [3:0] m;
      xi = int'(x);
      zi = int'(z);
      m  = 4'b0000;
      for (int c = 1; c < WORLD_CHUNKS; c++) begin
         if (xi == c * CHUNK_WIDTH) m[0] = 1'b1;
         if (zi == c * CHUNK_WIDTH) m[2] = 1'b1;
      end
      for (int c = 0; c < WORLD_CHUNKS - 1; c++) begin
         if (xi == c * CHUNK_WIDTH + CHUNK_WIDTH - 1) m[1] = 1'b1;
         if (zi == c * CHUNK_WIDTH + CHUNK_WIDTH - 1) m[3] = 1'b1;
      end
      return m;
   endfunction

endpackage

// ===== rtl/vgrt_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vgrt_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module vgrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/vgrt_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vgrt_div
// Restoring divider, one quotient bit per cycle, 31-bit dividend.
// ============================================================================
module vgrt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  vgrt_pkg::div_req_type req,
   output vgrt_pkg::div_rsp_type rsp
);
   import vgrt_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [30:0] num_ff, num_in;
   logic [30:0] quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] trial;
   logic [16:0] diff;

   assign trial = {rem_ff, num_ff[30]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = 16'd0;
         num_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         num_in = {num_ff[29:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[29:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[29:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = {1'b0, quo_ff};
endmodule

// ===== rtl/voxel_grid_ray_traversal_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// voxel_grid_ray_traversal_top
// Voxel grid store with write, read and Amanatides-Woo ray trace requests.
// ============================================================================
//
//  Channel   Direction  Handshake             Carries
//  req_      in         req_valid/req_ready   one request word
//  rsp_      out        rsp_valid/rsp_ready   one result word per request
//  csr_      in         csr_wr_en             max_distance, written at once
//
// A write passes through ST_DONE to the result register, and a read through
// ST_RDWAIT and ST_DONE. A trace runs the shared one-bit-per-cycle divider up
// to six times for its set-up and then walks the grid, with an ST_STEP and an
// ST_PROBE for each in-grid voxel and only an ST_STEP for a voxel outside the
// grid; the single read port of the voxel memory probes each in-grid voxel.
// After reset the memory's 262144 entries are cleared one entry per cycle while
// req_ready stays low. A new request is accepted while a result waits on
// rsp_ready; a finished request then holds until the result register frees.
//
module voxel_grid_ray_traversal_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic signed [15:0]  req_voxel_x,
   input  logic signed [15:0]  req_voxel_y,
   input  logic signed [15:0]  req_voxel_z,
   input  logic [7:0]          req_block_id,
   input  logic signed [23:0]  req_origin_x,
   input  logic signed [23:0]  req_origin_y,
   input  logic signed [23:0]  req_origin_z,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic signed [15:0]  req_dir_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_read_id,
   output logic [3:0]          rsp_redraw_mask,
   output logic                rsp_hit,
   output logic [7:0]          rsp_hit_x,
   output logic [7:0]          rsp_hit_y,
   output logic [7:0]          rsp_hit_z,
   output logic signed [15:0]  rsp_prev_x,
   output logic signed [15:0]  rsp_prev_y,
   output logic signed [15:0]  rsp_prev_z,
   input  logic                csr_wr_en,
   input  logic [23:0]         csr_wr_data
);
   import vgrt_pkg::*;

   // Controller states.
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_RDWAIT = 3'd2;
   localparam logic [2:0] ST_DIVGO  = 3'd3;
   localparam logic [2:0] ST_DIVWT  = 3'd4;
   localparam logic [2:0] ST_STEP   = 3'd5;
   localparam logic [2:0] ST_PROBE  = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W:0]   clr_ff, clr_in;
   logic [23:0]       max_dist_ff;

   // Trace working set, one entry per axis (x, y, z).
   logic signed [23:0] org_ff   [3];
   logic signed [23:0] org_in   [3];
   logic signed [15:0] dir_ff   [3];
   logic signed [15:0] dir_in   [3];
   logic signed [15:0] vox_ff   [3];
   logic signed [15:0] vox_in   [3];
   logic signed [15:0] prev_ff  [3];
   logic signed [15:0] prev_in  [3];
   logic [31:0]        tnext_ff [3];
   logic [31:0]        tnext_in [3];
   logic [31:0]        tdel_ff  [3];
   logic [31:0]        tdel_in  [3];
   logic [31:0]        tcur_ff, tcur_in;
   logic [1:0]         axis_ff, axis_in;
   logic               phase_ff, phase_in;

   logic               rd_grid_ff, rd_grid_in;
   logic [7:0]         res_id_ff, res_id_in;
   logic [3:0]         res_mask_ff, res_mask_in;
   logic               res_hit_ff, res_hit_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         out_id_ff;
   logic [3:0]         out_mask_ff;
   logic               out_hit_ff;
   logic [7:0]         out_hx_ff, out_hy_ff, out_hz_ff;
   logic signed [15:0] out_px_ff, out_py_ff, out_pz_ff;
   logic               load_out;

   // Memory port.
   logic                ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ID_BITS-1:0]  ram_wr_data, ram_rd_data;
   logic [ID_BITS+7:0]  id_wide_w, id_wide_r;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               accept;
   logic               req_in_grid;
   logic [ADDR_W-1:0]  req_addr;

   // Step selection.
   logic               sel_x, sel_y;
   logic [1:0]         sel;
   logic signed [15:0] nvox [3];
   logic [32:0]        tsum;
   logic               do_adv;

   // Set-up numerators for the axis in hand.
   logic signed [15:0] cur_dir;
   logic [15:0]        cur_frac;
   logic [16:0]        cur_dist;
   logic [15:0]        cur_mag;
   logic [15:0]        neg_dir;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_in_grid = in_grid(req_voxel_x, req_voxel_y, req_voxel_z);
   assign req_addr    = cell_addr(req_voxel_x, req_voxel_y, req_voxel_z);

   assign id_wide_w = {{ID_BITS{1'b0}}, req_block_id};
   assign id_wide_r = {8'd0, ram_rd_data};

   assign cur_dir  = dir_ff[axis_ff];
   assign cur_frac = org_ff[axis_ff][15:0];
   assign cur_dist = cur_dir[15] ? {1'b0, cur_frac} : (17'h10000 - {1'b0, cur_frac});
   assign neg_dir  = 16'd0 - cur_dir;
   // The magnitude of the most negative direction needs all 16 bits.
   assign cur_mag  = cur_dir[15] ? neg_dir : cur_dir;

   // Ties go to z, then y.
   assign sel_x = (tnext_ff[0] < tnext_ff[1]) && (tnext_ff[0] < tnext_ff[2]);
   assign sel_y = !sel_x && (tnext_ff[0] >= tnext_ff[1]) && (tnext_ff[1] < tnext_ff[2]);
   assign sel   = sel_x ? 2'd0 : (sel_y ? 2'd1 : 2'd2);
   assign tsum  = {1'b0, tnext_ff[sel]} + {1'b0, tdel_ff[sel]};

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         nvox[a] = vox_ff[a];
      end
      nvox[sel] = dir_ff[sel][15] ? (vox_ff[sel] - 16'sd1) : (vox_ff[sel] + 16'sd1);
   end

   assign load_out     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      org_in      = org_ff;
      dir_in      = dir_ff;
      vox_in      = vox_ff;
      prev_in     = prev_ff;
      tnext_in    = tnext_ff;
      tdel_in     = tdel_ff;
      tcur_in     = tcur_ff;
      axis_in     = axis_ff;
      phase_in    = phase_ff;
      rd_grid_in  = rd_grid_ff;
      res_id_in   = res_id_ff;
      res_mask_in = res_mask_ff;
      res_hit_in  = res_hit_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_addr;
      ram_wr_data = id_wide_w[ID_BITS-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = req_addr;
      div_req     = '0;
      do_adv      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff[ADDR_W-1:0];
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == (ADDR_W + 1)'(STORE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_id_in   = 8'd0;
               res_mask_in = 4'd0;
               res_hit_in  = 1'b0;
               for (int a = 0; a < 3; a++) begin
                  vox_in[a]  = 16'sd0;
                  prev_in[a] = 16'sd0;
               end
               case (req_type)
                  REQ_WRITE: begin
                     ram_wr_en = req_in_grid;
                     if (req_in_grid) begin
                        res_mask_in = redraw_bits(req_voxel_x, req_voxel_z);
                     end
                     state_in = ST_DONE;
                  end
                  REQ_READ: begin
                     ram_rd_en  = req_in_grid;
                     rd_grid_in = req_in_grid;
                     state_in   = ST_RDWAIT;
                  end
                  REQ_TRACE: begin
                     org_in[0] = req_origin_x;
                     org_in[1] = req_origin_y;
                     org_in[2] = req_origin_z;
                     dir_in[0] = req_dir_x;
                     dir_in[1] = req_dir_y;
                     dir_in[2] = req_dir_z;
                     // Start voxel is the floor of the origin.
                     vox_in[0]  = 16'(req_origin_x >>> 16);
                     vox_in[1]  = 16'(req_origin_y >>> 16);
                     vox_in[2]  = 16'(req_origin_z >>> 16);
                     prev_in[0] = 16'(req_origin_x >>> 16);
                     prev_in[1] = 16'(req_origin_y >>> 16);
                     prev_in[2] = 16'(req_origin_z >>> 16);
                     axis_in  = 2'd0;
                     phase_in = 1'b0;
                     tcur_in  = 32'd0;
                     state_in = ST_DIVGO;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            res_id_in = rd_grid_ff ? id_wide_r[7:0] : 8'd0;
            state_in  = ST_DONE;
         end
         ST_DIVGO: begin
            if (cur_dir == 16'sd0) begin
               tnext_in[axis_ff] = T_SAT;
               tdel_in[axis_ff]  = T_SAT;
               do_adv            = 1'b1;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = phase_ff ? {cur_dist, 14'd0} : 31'h4000_0000;
               div_req.den   = cur_mag;
               state_in      = ST_DIVWT;
            end
         end
         ST_DIVWT: begin
            if (div_rsp.done) begin
               if (!phase_ff) begin
                  tdel_in[axis_ff] = div_rsp.quo;
                  phase_in         = 1'b1;
                  state_in         = ST_DIVGO;
               end else begin
                  tnext_in[axis_ff] = div_rsp.quo;
                  do_adv            = 1'b1;
               end
            end
         end
         ST_STEP: begin
            if (tcur_ff < {8'd0, max_dist_ff}) begin
               prev_in        = vox_ff;
               vox_in         = nvox;
               tcur_in        = tnext_ff[sel];
               tnext_in[sel]  = tsum[32] ? T_SAT : tsum[31:0];
               if (in_grid(nvox[0], nvox[1], nvox[2])) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = cell_addr(nvox[0], nvox[1], nvox[2]);
                  state_in    = ST_PROBE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PROBE: begin
            if (ram_rd_data != '0) begin
               res_hit_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move on to the next axis; after the last axis, walk unless the direction is all zero.
      if (do_adv) begin
         phase_in = 1'b0;
         if (axis_ff == 2'd2) begin
            if (dir_ff[0] != 16'sd0 || dir_ff[1] != 16'sd0 || dir_ff[2] != 16'sd0) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_DONE;
            end
         end else begin
            axis_in  = axis_ff + 2'd1;
            state_in = ST_DIVGO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         max_dist_ff  <= 24'h08_0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_dist_ff <= csr_wr_data;
         end
      end
      org_ff      <= org_in;
      dir_ff      <= dir_in;
      vox_ff      <= vox_in;
      prev_ff     <= prev_in;
      tnext_ff    <= tnext_in;
      tdel_ff     <= tdel_in;
      tcur_ff     <= tcur_in;
      axis_ff     <= axis_in;
      phase_ff    <= phase_in;
      rd_grid_ff  <= rd_grid_in;
      res_id_ff   <= res_id_in;
      res_mask_ff <= res_mask_in;
      res_hit_ff  <= res_hit_in;
      if (load_out) begin
         out_id_ff   <= res_id_ff;
         out_mask_ff <= res_mask_ff;
         out_hit_ff  <= res_hit_ff;
         out_hx_ff   <= res_hit_ff ? vox_ff[0][7:0] : 8'd0;
         out_hy_ff   <= res_hit_ff ? vox_ff[1][7:0] : 8'd0;
         out_hz_ff   <= res_hit_ff ? vox_ff[2][7:0] : 8'd0;
         out_px_ff   <= prev_ff[0];
         out_py_ff   <= prev_ff[1];
         out_pz_ff   <= prev_ff[2];
      end
   end

   vgrt_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   vgrt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_id     = out_id_ff;
   assign rsp_redraw_mask = out_mask_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_hit_x       = out_hx_ff;
   assign rsp_hit_y       = out_hy_ff;
   assign rsp_hit_z       = out_hz_ff;
   assign rsp_prev_x      = out_px_ff;
   assign rsp_prev_y      = out_py_ff;
   assign rsp_prev_z      = out_pz_ff;
endmodule

// ===== rtl/vgrt_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vgrt_checker
// Port-level checks on the result word of the voxel grid traversal block.
// ============================================================================
`include "voxel_grid_ray_traversal_top_macros.svh"

module vgrt_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [7:0]          rsp_read_id,
   input logic [3:0]          rsp_redraw_mask,
   input logic                rsp_hit,
   input logic [7:0]          rsp_hit_x,
   input logic [7:0]          rsp_hit_y,
   input logic [7:0]          rsp_hit_z,
   input logic signed [15:0]  rsp_prev_x,
   input logic signed [15:0]  rsp_prev_y,
   input logic signed [15:0]  rsp_prev_z
);
   // A stalled result word stays offered.
   `VGRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // A miss, or a request other than a trace, carries no hit coordinates.
   `VGRT_ASSERT_NOW(a_miss_clean, rsp_valid && !rsp_hit,
      rsp_hit_x == 8'd0 && rsp_hit_y == 8'd0 && rsp_hit_z == 8'd0)
   // A redraw mask only comes from a write.
   `VGRT_ASSERT_NOW(a_mask_alone, rsp_valid && rsp_redraw_mask != 4'd0,
      rsp_read_id == 8'd0 && !rsp_hit)
   // A read result carries nothing of a trace.
   `VGRT_ASSERT_NOW(a_read_alone, rsp_valid && rsp_read_id != 8'd0,
      !rsp_hit && rsp_prev_x == 16'sd0 && rsp_prev_y == 16'sd0 && rsp_prev_z == 16'sd0)
endmodule

bind voxel_grid_ray_traversal_top vgrt_checker u_vgrt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_id     (rsp_read_id),
   .rsp_redraw_mask (rsp_redraw_mask),
   .rsp_hit         (rsp_hit),
   .rsp_hit_x       (rsp_hit_x),
   .rsp_hit_y       (rsp_hit_y),
   .rsp_hit_z       (rsp_hit_z),
   .rsp_prev_x      (rsp_prev_x),
   .rsp_prev_y      (rsp_prev_y),
   .rsp_prev_z      (rsp_prev_z)
);

// ===== sim/voxel_grid_ray_traversal_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Voxel grid ray traversal testbench
// Drives write, read and trace request words into the block and checks each
// result word against a cycle-free predictor of the grid store and the ray walk.
// ============================================================================
module voxel_grid_ray_traversal_top_tb;
   import vgrt_pkg::*;

   // One request word as it sits on the req_ ports.
   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] vx, vy, vz;
      logic [7:0]         id;
      logic signed [23:0] ox, oy, oz;
      logic signed [15:0] dx, dy, dz;
   } voxel_req_type;

   // One result word as it sits on the rsp_ ports.
   typedef struct {
      logic [7:0]         read_id;
      logic [3:0]         mask;
      logic               hit;
      logic [7:0]         hx, hy, hz;
      logic signed [15:0] px, py, pz;
   } voxel_rsp_type;

   localparam int  STALL_LIMIT = 1200000;
   localparam int  DENSE_LO    = 18;
   localparam int  DENSE_HI    = 29;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = REQ_WRITE;
   logic signed [15:0] req_voxel_x = '0, req_voxel_y = '0, req_voxel_z = '0;
   logic [7:0]         req_block_id = '0;
   logic signed [23:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_read_id;
   logic [3:0]         rsp_redraw_mask;
   logic               rsp_hit;
   logic [7:0]         rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic signed [15:0] rsp_prev_x, rsp_prev_y, rsp_prev_z;
   logic               csr_wr_en = 1'b0;
   logic [23:0]        csr_wr_data = '0;

   // Predictor state: a mirror of the voxel store and of the distance limit.
   logic [7:0]  grid_ids [0:STORE_SIZE-1];
   logic [31:0] trace_limit;

   voxel_req_type  pending_reqs [$];
   voxel_rsp_type  expected_rsps [$];
   voxel_req_type  cur_req;
   int          error_count = 0;
   int          words_in = 0, words_out = 0, trace_hits = 0, trace_count = 0;
   int          burst_left = 0, gap_left = 0, idle_cycles = 0;
   int unsigned cycle_count = 0;

   voxel_grid_ray_traversal_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic bit in_world(int x, int y, int z);
      return x >= 0 && x < GRID_W && z >= 0 && z < GRID_W && y >= 0 && y < GRID_HEIGHT;
   endfunction

   function automatic int grid_index(int x, int y, int z);
      return (x * GRID_HEIGHT + y) * GRID_W + z;
   endfunction

   function automatic logic [7:0] stored_id(int x, int y, int z);
      return in_world(x, y, z) ? grid_ids[grid_index(x, y, z)] : 8'd0;
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? T_SAT : s[31:0];
   endfunction

   // Start voxel, step sign, first boundary crossing and crossing spacing of one axis.
   function automatic void axis_start(input int org, input int d, output int vox,
                                      output int stp, output logic [31:0] t_first,
                                      output logic [31:0] t_delta);
      longint unsigned frac, mag, span;
      frac = org & 32'hFFFF;
      vox  = (org - int'(frac)) >>> 16;
      stp  = (d < 0) ? -1 : 1;
      if (d == 0) begin
         t_first = T_SAT;
         t_delta = T_SAT;
         return;
      end
      mag     = (d < 0) ? -d : d;
      span    = (d > 0) ? 65536 - frac : frac;
      t_delta = 32'((64'd1 << 30) / mag);
      t_first = 32'((span << 14) / mag);
   endfunction

   function automatic voxel_rsp_type predict_request(voxel_req_type r);
      voxel_rsp_type  o;
      int          x, y, z, vx, vy, vz, sx, sy, sz, px, py, pz;
      logic [31:0] tx, ty, tz, ddx, ddy, ddz, tcur;
      bit          found;
      o = '{default: '0};
      x = r.vx;
      y = r.vy;
      z = r.vz;
      case (r.kind)
         REQ_WRITE: begin
            if (in_world(x, y, z)) begin
               grid_ids[grid_index(x, y, z)] = r.id;
               if (x % CHUNK_WIDTH == 0 && x / CHUNK_WIDTH > 0) o.mask[0] = 1'b1;
               if (x % CHUNK_WIDTH == CHUNK_WIDTH - 1 && x / CHUNK_WIDTH < WORLD_CHUNKS - 1)
                  o.mask[1] = 1'b1;
               if (z % CHUNK_WIDTH == 0 && z / CHUNK_WIDTH > 0) o.mask[2] = 1'b1;
               if (z % CHUNK_WIDTH == CHUNK_WIDTH - 1 && z / CHUNK_WIDTH < WORLD_CHUNKS - 1)
                  o.mask[3] = 1'b1;
            end
         end
         REQ_READ: o.read_id = stored_id(x, y, z);
         REQ_TRACE: begin
            axis_start(r.ox, r.dx, vx, sx, tx, ddx);
            axis_start(r.oy, r.dy, vy, sy, ty, ddy);
            axis_start(r.oz, r.dz, vz, sz, tz, ddz);
            px    = vx;
            py    = vy;
            pz    = vz;
            tcur  = '0;
            found = 1'b0;
            if (r.dx != 0 || r.dy != 0 || r.dz != 0) begin
               while (!found && tcur < trace_limit) begin
                  px = vx;
                  py = vy;
                  pz = vz;
                  // Ties go to z first, then y.
                  if (tx < ty && tx < tz) begin
                     tcur = tx;
                     vx += sx;
                     tx = add_sat(tx, ddx);
                  end else if (tx >= ty && ty < tz) begin
                     tcur = ty;
                     vy += sy;
                     ty = add_sat(ty, ddy);
                  end else begin
                     tcur = tz;
                     vz += sz;
                     tz = add_sat(tz, ddz);
                  end
                  found = (stored_id(vx, vy, vz) != 0);
               end
            end
            if (found) begin
               o.hit = 1'b1;
               o.hx  = vx[7:0];
               o.hy  = vy[7:0];
               o.hz  = vz[7:0];
            end
            o.px = px[15:0];
            o.py = py[15:0];
            o.pz = pz[15:0];
         end
         default: ;
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic voxel_req_type blank_req(logic [1:0] kind);
      voxel_req_type r;
      r = '{default: '0};
      r.kind = kind;
      return r;
   endfunction

   function automatic voxel_req_type voxel_req(logic [1:0] kind, int x, int y, int z, int id);
      voxel_req_type r;
      r = blank_req(kind);
      r.vx = x;
      r.vy = y;
      r.vz = z;
      r.id = id;
      return r;
   endfunction

   function automatic voxel_req_type ray_req(int ox, int oy, int oz, int dx, int dy, int dz);
      voxel_req_type r;
      r = blank_req(REQ_TRACE);
      r.ox = ox;
      r.oy = oy;
      r.oz = oz;
      r.dx = dx;
      r.dy = dy;
      r.dz = dz;
      return r;
   endfunction

   function automatic int rand_dir();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 16384;
         2:       return -16384;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   // Mostly well-formed work around a dense block of voxels so that traces hit,
   // with a share of words carrying arbitrary bits in every field.
   function automatic voxel_req_type random_req();
      voxel_req_type r;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         r = voxel_req(REQ_WRITE, $urandom_range(DENSE_LO, DENSE_HI),
                       $urandom_range(DENSE_LO, DENSE_HI), $urandom_range(DENSE_LO, DENSE_HI),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
         if ($urandom_range(0, 4) == 0) begin
            r.vx = $urandom_range(0, GRID_W - 1);
            r.vy = $urandom_range(0, GRID_HEIGHT - 1);
            r.vz = $urandom_range(0, GRID_W - 1);
         end
      end else if (pick < 55) begin
         r = voxel_req(REQ_READ, $urandom_range(DENSE_LO - 2, DENSE_HI + 2),
                       $urandom_range(DENSE_LO - 2, DENSE_HI + 2),
                       $urandom_range(DENSE_LO - 2, DENSE_HI + 2), 0);
      end else if (pick < 88) begin
         if ($urandom_range(0, 2) == 0)
            r = ray_req($urandom_range(0, (GRID_W << 16) - 1),
                        $urandom_range(0, (GRID_HEIGHT << 16) - 1),
                        $urandom_range(0, (GRID_W << 16) - 1),
                        rand_dir(), rand_dir(), rand_dir());
         else
            r = ray_req($urandom_range(12 << 16, 36 << 16), $urandom_range(12 << 16, 36 << 16),
                        $urandom_range(12 << 16, 36 << 16), rand_dir(), rand_dir(), rand_dir());
      end else begin
         r.kind = $urandom_range(0, 3);
         r.vx   = $urandom;
         r.vy   = $urandom;
         r.vz   = $urandom;
         r.id   = $urandom;
         r.ox   = $urandom;
         r.oy   = $urandom;
         r.oz   = $urandom;
         r.dx   = $urandom;
         r.dy   = $urandom;
         r.dz   = $urandom;
      end
      return r;
   endfunction

   // The limit is only changed with nothing in flight.
   task automatic set_trace_limit(logic [23:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      trace_limit  = {8'd0, value};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [23:0] limits [6];
      foreach (grid_ids[i]) grid_ids[i] = '0;
      trace_limit = 32'd524288;
      limits = '{24'd524288, 24'd0, 24'hFFFFFF, 24'd65536, 24'd1, 24'd0};
      limits[5] = $urandom_range(1, 24'hFFFFFF);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words: grid corners, chunk borders, outside writes and reads,
      // an id of all ones, clearing a voxel, and traces with ties, zero
      // directions, full-scale directions and origins outside the grid.
      set_trace_limit(24'd524288);
      pending_reqs.push_back(voxel_req(REQ_WRITE, 0, 0, 0, 255));
      pending_reqs.push_back(voxel_req(REQ_WRITE, GRID_W - 1, GRID_HEIGHT - 1, GRID_W - 1, 7));
      pending_reqs.push_back(voxel_req(REQ_WRITE, 16, 5, 15, 3));
      pending_reqs.push_back(voxel_req(REQ_WRITE, 15, 5, 48, 4));
      pending_reqs.push_back(voxel_req(REQ_WRITE, 47, 5, 31, 5));
      pending_reqs.push_back(voxel_req(REQ_WRITE, -1, 0, 0, 9));
      pending_reqs.push_back(voxel_req(REQ_WRITE, GRID_W, 0, 0, 9));
      pending_reqs.push_back(voxel_req(REQ_WRITE, 0, GRID_HEIGHT, 0, 9));
      pending_reqs.push_back(voxel_req(REQ_WRITE, 0, 0, -32768, 9));
      pending_reqs.push_back(voxel_req(REQ_READ, 0, 0, 0, 0));
      pending_reqs.push_back(voxel_req(REQ_READ, GRID_W - 1, GRID_HEIGHT - 1, GRID_W - 1, 0));
      pending_reqs.push_back(voxel_req(REQ_READ, -32768, 32767, 0, 0));
      pending_reqs.push_back(ray_req(32'h38000, 32'h8000, 32'h8000, -16384, 0, 0));
      pending_reqs.push_back(ray_req(32'h8000, 32'h8000, 32'h38000, 0, 0, -16384));
      pending_reqs.push_back(ray_req(32'h18000, 32'h18000, 32'h18000, -9459, -9459, -9459));
      pending_reqs.push_back(ray_req(32'h8000, 32'h8000, 32'h8000, 0, 0, 0));
      pending_reqs.push_back(ray_req(-8388608, 8388607, -8388608, 16384, -16384, 16384));
      pending_reqs.push_back(ray_req(32'h10000, 32'h10000, 32'h10000, 16384, 16384, 0));
      pending_reqs.push_back(ray_req(32'h3E8000, 32'h3E8000, 32'h3E8000, 9459, 9459, 9459));
      pending_reqs.push_back(ray_req(32'h18000, 32'h8000, 32'h8000, -32768, 32767, 0));
      pending_reqs.push_back(voxel_req(2'd3, 1, 1, 1, 1));
      pending_reqs.push_back(voxel_req(REQ_WRITE, 0, 0, 0, 0));
      pending_reqs.push_back(ray_req(32'h38000, 32'h8000, 32'h8000, -16384, 0, 0));
      wait_quiet();

      // Random phases, each under its own distance limit.
      foreach (limits[p]) begin
         set_trace_limit(limits[p]);
         for (int i = 0; i < 172; i++) pending_reqs.push_back(random_req());
         wait_quiet();
      end

      $display("Covered %0d request words: %0d traces, %0d of them hits, over six limits.",
               words_in, trace_count, trace_hits);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: bursts of words separated by random gaps.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 8);
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_request(cur_req));
            words_in++;
            if (cur_req.kind == REQ_TRACE) trace_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               req_type     <= cur_req.kind;
               req_voxel_x  <= cur_req.vx;
               req_voxel_y  <= cur_req.vy;
               req_voxel_z  <= cur_req.vz;
               req_block_id <= cur_req.id;
               req_origin_x <= cur_req.ox;
               req_origin_y <= cur_req.oy;
               req_origin_z <= cur_req.oz;
               req_dir_x    <= cur_req.dx;
               req_dir_y    <= cur_req.dy;
               req_dir_z    <= cur_req.dz;
               req_valid    <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: ready pattern follows bits 10:9 of the cycle count, between always ready,
   // random stalls and a fixed duty cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[10:9])
         2'd0, 2'd3: rsp_ready <= 1'b1;
         2'd1:       rsp_ready <= ($urandom_range(0, 2) != 0);
         default:    rsp_ready <= (cycle_count[3:0] < 4'd5);
      endcase
   end

   // Monitor: every result word is compared with the oldest expectation.
   always @(posedge clock) begin
      voxel_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         words_out++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: result word with no request outstanding", $time);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_hit) trace_hits++;
            if ({rsp_read_id, rsp_redraw_mask, rsp_hit, rsp_hit_x, rsp_hit_y, rsp_hit_z,
                 rsp_prev_x, rsp_prev_y, rsp_prev_z} !==
                {e.read_id, e.mask, e.hit, e.hx, e.hy, e.hz, e.px, e.py, e.pz}) begin
               $display("%0t: mismatch expected id=%0d mask=%h hit=%b at %0d,%0d,%0d prev %0d,%0d,%0d",
                        $time, e.read_id, e.mask, e.hit, e.hx, e.hy, e.hz, e.px, e.py, e.pz);
               $display("%0t:          actual id=%0d mask=%h hit=%b at %0d,%0d,%0d prev %0d,%0d,%0d",
                        $time, rsp_read_id, rsp_redraw_mask, rsp_hit, rsp_hit_x, rsp_hit_y,
                        rsp_hit_z, rsp_prev_x, rsp_prev_y, rsp_prev_z);
               error_count++;
            end
         end
      end
   end

   // Watchdog: the limit covers the clearing pass of the store after reset.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule
